>>> design/xpmd_pkg.sv
// ----------------------------------------------------------------------------
// xpmd_pkg
// Types, codes and helper functions shared by the x86 prefix/ModRM decoder.
// ----------------------------------------------------------------------------
package xpmd_pkg;

    localparam int RF_DEPTH     = 17;
    localparam int RF_AW        = $clog2(RF_DEPTH);
    localparam int PREFIX_LIMIT = 15;
    localparam int PFX_CNT_W    = 5;
    localparam int LEN_W        = 5;

    localparam logic [RF_AW-1:0] RIP_ADDR = RF_AW'(RF_DEPTH - 1);

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_START   = 2'd1,
        CMD_OPBYTE  = 2'd2,
        CMD_MODBYTE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_OPCODE  = 2'd0,
        KIND_OPERAND = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_SECOND = 3'd2,
        PH_MODRM  = 3'd3,
        PH_SIB    = 3'd4,
        PH_DISP   = 3'd5,
        PH_DONE   = 3'd6,
        PH_ERROR  = 3'd7
    } t_phase;

    // operand / address size codes
    localparam logic [1:0] SZ16 = 2'd0;
    localparam logic [1:0] SZ32 = 2'd1;
    localparam logic [1:0] SZ64 = 2'd2;

    localparam logic [1:0] SEG_NONE = 2'd0;
    localparam logic [1:0] SEG_FS   = 2'd1;
    localparam logic [1:0] SEG_GS   = 2'd2;

    localparam logic [1:0] REP_NONE = 2'd0;
    localparam logic [1:0] REP_Z    = 2'd1;
    localparam logic [1:0] REP_NZ   = 2'd2;

    // prefix and opcode bytes
    localparam logic [7:0] PFX_ES     = 8'h26;
    localparam logic [7:0] PFX_CS     = 8'h2E;
    localparam logic [7:0] PFX_SS     = 8'h36;
    localparam logic [7:0] PFX_DS     = 8'h3E;
    localparam logic [7:0] PFX_FS     = 8'h64;
    localparam logic [7:0] PFX_GS     = 8'h65;
    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] PFX_ADSIZE = 8'h67;
    localparam logic [7:0] PFX_LOCK   = 8'hF0;
    localparam logic [7:0] PFX_REPNZ  = 8'hF2;
    localparam logic [7:0] PFX_REPZ   = 8'hF3;
    localparam logic [7:0] REX_FIRST  = 8'h40;
    localparam logic [7:0] REX_LAST   = 8'h4F;
    localparam logic [7:0] OPC_ESCAPE = 8'h0F;

    // ModRM / SIB special encodings
    localparam logic [1:0] MOD_MEM0   = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP    = 3'd5;
    localparam logic [3:0] IDX_NONE   = 4'd4;

    localparam logic [2:0] DSZ_NONE = 3'd0;
    localparam logic [2:0] DSZ_1    = 3'd1;
    localparam logic [2:0] DSZ_4    = 3'd4;

    // one result descriptor, built when a byte is accepted
    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [15:0]       opcode;
        logic [1:0]        dsize;
        logic [1:0]        asize;
        logic [1:0]        seg;
        logic [1:0]        rep;
        logic [1:0]        mod;
        logic [3:0]        reg_num;
        logic [3:0]        rm_num;
        logic [LEN_W-1:0]  length;
        logic              use_reg;
        logic              use_a;
        logic              use_b;
        logic [1:0]        scale;
        logic [63:0]       disp;
    } t_req;

    typedef struct packed {
        logic [RF_AW-1:0] reg_addr;
        logic [RF_AW-1:0] a_addr;
        logic [RF_AW-1:0] b_addr;
    } t_rd_addr;

    function automatic logic [2:0] disp_size(input logic [7:0] modrm, input logic [7:0] sib);
        logic [2:0] sz;
        sz = DSZ_NONE;
        if (modrm[7:6] == MOD_DISP8) begin
            sz = DSZ_1;
        end else if (modrm[7:6] == MOD_DISP32) begin
            sz = DSZ_4;
        end else if (modrm[7:6] == MOD_MEM0) begin
            if (modrm[2:0] == RM_DISP) begin
                sz = DSZ_4;
            end else if (modrm[2:0] == RM_SIB && sib[2:0] == RM_DISP) begin
                sz = DSZ_4;
            end
        end
        return sz;
    endfunction

    function automatic logic [63:0] disp_value(input logic [31:0] bytes, input logic [2:0] sz);
        logic [63:0] v;
        case (sz)
            DSZ_1:   v = {{56{bytes[7]}}, bytes[7:0]};
            DSZ_4:   v = {{32{bytes[31]}}, bytes};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/xpmd_ram.sv
// ----------------------------------------------------------------------------
// xpmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xpmd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/xpmd_decode.sv
// ----------------------------------------------------------------------------
// xpmd_decode
// Per-instruction decode state: prefixes, opcode, ModRM, SIB, displacement.
// Builds the result descriptor and register read addresses for each byte.
// ----------------------------------------------------------------------------
module xpmd_decode
    import xpmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_command,
    input  logic [7:0] i_byte_value,
    output t_req       o_req,
    output t_rd_addr   o_rd
);

    t_phase               r_phase,   n_phase;
    logic [7:0]           r_rex,     n_rex;
    logic [1:0]           r_osize,   n_osize;
    logic [1:0]           r_asize,   n_asize;
    logic [1:0]           r_seg,     n_seg;
    logic [1:0]           r_rep,     n_rep;
    logic [PFX_CNT_W-1:0] r_pfx_cnt, n_pfx_cnt;
    logic [LEN_W-1:0]     r_len,     n_len;
    logic [15:0]          r_opcode,  n_opcode;
    logic [7:0]           r_modrm,   n_modrm;
    logic [7:0]           r_sib,     n_sib;
    logic [31:0]          r_disp,    n_disp;
    logic [2:0]           r_left,    n_left;

    logic                 emit;
    t_kind                kind;
    logic                 finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_rex     <= '0;
            r_osize   <= SZ32;
            r_asize   <= SZ64;
            r_seg     <= SEG_NONE;
            r_rep     <= REP_NONE;
            r_pfx_cnt <= '0;
            r_len     <= '0;
            r_opcode  <= '0;
            r_modrm   <= '0;
            r_sib     <= '0;
            r_disp    <= '0;
            r_left    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_rex     <= n_rex;
            r_osize   <= n_osize;
            r_asize   <= n_asize;
            r_seg     <= n_seg;
            r_rep     <= n_rep;
            r_pfx_cnt <= n_pfx_cnt;
            r_len     <= n_len;
            r_opcode  <= n_opcode;
            r_modrm   <= n_modrm;
            r_sib     <= n_sib;
            r_disp    <= n_disp;
            r_left    <= n_left;
        end
    end

    always_comb begin
        logic       is_pfx;
        logic       after;
        logic [2:0] ds_cur;
        logic [2:0] ds_new;
        logic [1:0] got;

        n_phase   = r_phase;
        n_rex     = r_rex;
        n_osize   = r_osize;
        n_asize   = r_asize;
        n_seg     = r_seg;
        n_rep     = r_rep;
        n_pfx_cnt = r_pfx_cnt;
        n_len     = r_len;
        n_opcode  = r_opcode;
        n_modrm   = r_modrm;
        n_sib     = r_sib;
        n_disp    = r_disp;
        n_left    = r_left;
        emit      = 1'b0;
        kind      = KIND_OPCODE;
        finish    = 1'b0;
        is_pfx    = 1'b0;
        after     = 1'b0;
        ds_cur    = disp_size(r_modrm, r_sib);
        ds_new    = DSZ_NONE;
        got       = 2'(ds_cur - r_left);

        if (i_accept) begin
            unique case (t_cmd'(i_command))
                CMD_LOAD: begin
                    n_phase = r_phase;
                end
                CMD_START: begin
                    n_rex     = '0;
                    n_osize   = SZ32;
                    n_asize   = SZ64;
                    n_seg     = SEG_NONE;
                    n_rep     = REP_NONE;
                    n_pfx_cnt = '0;
                    n_len     = '0;
                    n_opcode  = '0;
                    n_modrm   = '0;
                    n_sib     = '0;
                    n_disp    = '0;
                    n_left    = '0;
                    n_phase   = PH_PREFIX;
                end
                CMD_OPBYTE: begin
                    if (r_phase == PH_SECOND) begin
                        n_len    = r_len + 1'b1;
                        n_opcode = {OPC_ESCAPE, i_byte_value};
                        n_phase  = PH_MODRM;
                        emit     = 1'b1;
                    end else if (r_phase == PH_PREFIX) begin
                        n_len  = r_len + 1'b1;
                        is_pfx = 1'b1;
                        unique case (i_byte_value) inside
                            [REX_FIRST:REX_LAST]: begin
                                n_rex = i_byte_value;
                                if (i_byte_value[3]) begin
                                    n_osize = SZ64;
                                end
                            end
                            PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_LOCK: begin
                                is_pfx = 1'b1;
                            end
                            PFX_FS:     n_seg = SEG_FS;
                            PFX_GS:     n_seg = SEG_GS;
                            PFX_OPSIZE: begin
                                if (r_rex == '0) begin
                                    n_osize = SZ16;
                                end
                            end
                            PFX_ADSIZE: n_asize = SZ32;
                            PFX_REPZ:   n_rep   = REP_Z;
                            PFX_REPNZ:  n_rep   = REP_NZ;
                            default: begin
                                is_pfx   = 1'b0;
                                n_opcode = {8'h00, i_byte_value};
                                if (i_byte_value == OPC_ESCAPE) begin
                                    n_phase = PH_SECOND;
                                end else begin
                                    n_phase = PH_MODRM;
                                    emit    = 1'b1;
                                end
                            end
                        endcase
                        if (is_pfx) begin
                            n_pfx_cnt = r_pfx_cnt + 1'b1;
                            if (n_pfx_cnt > PFX_CNT_W'(PREFIX_LIMIT)) begin
                                n_phase = PH_ERROR;
                                emit    = 1'b1;
                                kind    = KIND_ERROR;
                            end
                        end
                    end
                end
                CMD_MODBYTE: begin
                    if (r_phase == PH_MODRM) begin
                        n_len   = r_len + 1'b1;
                        n_modrm = i_byte_value;
                        if (i_byte_value[7:6] != MOD_REG && i_byte_value[2:0] == RM_SIB) begin
                            n_phase = PH_SIB;
                        end else begin
                            after = 1'b1;
                        end
                    end else if (r_phase == PH_SIB) begin
                        n_len = r_len + 1'b1;
                        n_sib = i_byte_value;
                        after = 1'b1;
                    end else if (r_phase == PH_DISP) begin
                        n_len  = r_len + 1'b1;
                        n_disp = r_disp | (32'(i_byte_value) << {got, 3'b000});
                        n_left = r_left - 1'b1;
                        if (n_left == '0) begin
                            finish = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        // decide whether displacement bytes follow
        if (after) begin
            ds_new = disp_size(n_modrm, n_sib);
            if (ds_new == DSZ_NONE) begin
                finish = 1'b1;
            end else begin
                n_disp  = '0;
                n_left  = ds_new;
                n_phase = PH_DISP;
            end
        end

        if (finish) begin
            n_phase = PH_DONE;
            emit    = 1'b1;
            kind    = KIND_OPERAND;
        end
    end

    // result descriptor from the updated state
    always_comb begin
        logic [1:0] mod;
        logic [2:0] rm_lo;
        logic [3:0] idx;
        logic [3:0] reg_n;
        logic [3:0] rm_n;

        mod   = n_modrm[7:6];
        rm_lo = n_modrm[2:0];
        idx   = {n_rex[1], n_sib[5:3]};
        reg_n = {n_rex[2], n_modrm[5:3]};
        rm_n  = {n_rex[0], rm_lo};

        o_req         = '0;
        o_req.valid   = emit;
        o_req.kind    = kind;
        o_req.opcode  = (kind == KIND_ERROR) ? 16'h0000 : n_opcode;
        o_req.dsize   = n_osize;
        o_req.asize   = n_asize;
        o_req.seg     = n_seg;
        o_req.rep     = n_rep;
        o_req.length  = n_len;
        o_rd.reg_addr = RF_AW'(reg_n);
        o_rd.a_addr   = RF_AW'(rm_n);
        o_rd.b_addr   = RF_AW'(idx);

        if (kind == KIND_OPERAND) begin
            o_req.mod     = mod;
            o_req.reg_num = reg_n;
            o_req.rm_num  = rm_n;
            o_req.use_reg = 1'b1;
            o_req.disp    = disp_value(n_disp, disp_size(n_modrm, n_sib));
            if (mod == MOD_REG) begin
                o_req.use_a = 1'b1;
            end else if (mod == MOD_MEM0 && rm_lo == RM_DISP) begin
                // rip-relative, REX.B plays no part
                o_req.use_a = 1'b1;
                o_rd.a_addr = RIP_ADDR;
            end else if (rm_lo == RM_SIB) begin
                o_req.use_b   = (idx != IDX_NONE);
                o_req.scale   = n_sib[7:6];
                o_req.use_a   = !(n_sib[2:0] == RM_DISP && mod == MOD_MEM0);
                o_rd.a_addr   = RF_AW'({n_rex[0], n_sib[2:0]});
            end else begin
                o_req.use_a = 1'b1;
            end
        end
    end

endmodule

>>> design/xpmd_ea.sv
// ----------------------------------------------------------------------------
// xpmd_ea
// Effective-address adder and result register with output handshake.
// ----------------------------------------------------------------------------
module xpmd_ea
    import xpmd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_req,
    input  logic [63:0]       i_reg_q,
    input  logic [63:0]       i_a_q,
    input  logic [63:0]       i_b_q,
    input  logic              i_stall,
    output logic              o_ready,
    output logic              o_valid,
    output logic [1:0]        o_kind,
    output logic [15:0]       o_opcode,
    output logic [1:0]        o_data_size,
    output logic [1:0]        o_addr_size,
    output logic [1:0]        o_segment_override,
    output logic [1:0]        o_rep_mode,
    output logic [1:0]        o_mod_field,
    output logic [3:0]        o_reg_number,
    output logic [3:0]        o_rm_number,
    output logic [63:0]       o_reg_data,
    output logic [63:0]       o_rm_data,
    output logic [LEN_W-1:0]  o_length
);

    logic              r_valid;
    t_req              r_req;
    logic [63:0]       r_reg_data;
    logic [63:0]       r_rm_data;

    logic [63:0]       a_term;
    logic [63:0]       b_term;
    logic [63:0]       ea;

    assign a_term  = i_req.use_a ? i_a_q : 64'd0;
    assign b_term  = i_req.use_b ? (i_b_q << i_req.scale) : 64'd0;
    assign ea      = a_term + b_term + i_req.disp;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_req.valid;
        end
    end

    // payload: load only with a new request, hold while stalled
    always_ff @(posedge i_clk) begin
        if (o_ready && i_req.valid) begin
            r_req      <= i_req;
            r_reg_data <= i_req.use_reg ? i_reg_q : 64'd0;
            r_rm_data  <= ea;
        end
    end

    assign o_valid            = r_valid;
    assign o_kind             = r_req.kind;
    assign o_opcode           = r_req.opcode;
    assign o_data_size        = r_req.dsize;
    assign o_addr_size        = r_req.asize;
    assign o_segment_override = r_req.seg;
    assign o_rep_mode         = r_req.rep;
    assign o_mod_field        = r_req.mod;
    assign o_reg_number       = r_req.reg_num;
    assign o_rm_number        = r_req.rm_num;
    assign o_reg_data         = r_reg_data;
    assign o_rm_data          = r_rm_data;
    assign o_length           = r_req.length;

endmodule

>>> design/x86_prefix_modrm_decoder.sv
// ----------------------------------------------------------------------------
// x86_prefix_modrm_decoder
// Byte-serial x86-64 prefix, opcode and ModRM/SIB/displacement decoder.
// ----------------------------------------------------------------------------
// Takes one request per cycle while o_stall is low. A taken request first
// goes through the byte decode and the register file read (three copies of the
// 17-entry file, registered read ports for the reg operand, base or rip, and
// index) into the decode stage register, then through the base + index*scale
// + displacement add into the result register. The register file reads as
// zero until an entry is loaded; there is no clearing pass after reset. Input
// stall rises only while a result sits stalled at the output with another one
// queued behind it.
// ----------------------------------------------------------------------------
module x86_prefix_modrm_decoder
    import xpmd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic [4:0]        i_reg_index,
    input  logic [63:0]       i_reg_value,
    input  logic [7:0]        i_byte_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_kind,
    output logic [15:0]       o_opcode,
    output logic [1:0]        o_data_size,
    output logic [1:0]        o_addr_size,
    output logic [1:0]        o_segment_override,
    output logic [1:0]        o_rep_mode,
    output logic [1:0]        o_mod_field,
    output logic [3:0]        o_reg_number,
    output logic [3:0]        o_rm_number,
    output logic [63:0]       o_reg_data,
    output logic [63:0]       o_rm_data,
    output logic [4:0]        o_length
);

    logic                 accept;
    logic                 s1_adv;
    logic                 ea_ready;
    logic                 wr_en;
    t_req                 d_req;
    t_rd_addr             d_rd;

    t_req                 r_req;
    logic [RF_DEPTH-1:0]  r_rf_vld;
    logic                 r_vld_reg;
    logic                 r_vld_a;
    logic                 r_vld_b;

    logic [63:0]          q_reg;
    logic [63:0]          q_a;
    logic [63:0]          q_b;

    assign o_stall = r_req.valid && !ea_ready;
    assign s1_adv  = !o_stall;
    assign accept  = i_valid && !o_stall;
    assign wr_en   = accept && (t_cmd'(i_command) == CMD_LOAD)
                     && (i_reg_index <= RF_AW'(RF_DEPTH - 1));

    xpmd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_command),
        .i_byte_value (i_byte_value),
        .o_req        (d_req),
        .o_rd         (d_rd)
    );

    xpmd_ram #(.WIDTH(64), .DEPTH(RF_DEPTH)) u_ram_reg (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_reg_index),
        .i_wr_data (i_reg_value),
        .i_rd_en   (s1_adv),
        .i_rd_addr (d_rd.reg_addr),
        .o_rd_data (q_reg)
    );

    xpmd_ram #(.WIDTH(64), .DEPTH(RF_DEPTH)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_reg_index),
        .i_wr_data (i_reg_value),
        .i_rd_en   (s1_adv),
        .i_rd_addr (d_rd.a_addr),
        .o_rd_data (q_a)
    );

    xpmd_ram #(.WIDTH(64), .DEPTH(RF_DEPTH)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_reg_index),
        .i_wr_data (i_reg_value),
        .i_rd_en   (s1_adv),
        .i_rd_addr (d_rd.b_addr),
        .o_rd_data (q_b)
    );

    // written flags: an unwritten register reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (wr_en) begin
            r_rf_vld[i_reg_index] <= 1'b1;
        end
    end

    // decode stage register, aligned with the RAM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req     <= '0;
            r_vld_reg <= 1'b0;
            r_vld_a   <= 1'b0;
            r_vld_b   <= 1'b0;
        end else if (s1_adv) begin
            r_req     <= d_req;
            r_vld_reg <= r_rf_vld[d_rd.reg_addr];
            r_vld_a   <= r_rf_vld[d_rd.a_addr];
            r_vld_b   <= r_rf_vld[d_rd.b_addr];
        end
    end

    xpmd_ea u_ea (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req              (r_req),
        .i_reg_q            (r_vld_reg ? q_reg : 64'd0),
        .i_a_q              (r_vld_a ? q_a : 64'd0),
        .i_b_q              (r_vld_b ? q_b : 64'd0),
        .i_stall            (i_stall),
        .o_ready            (ea_ready),
        .o_valid            (o_valid),
        .o_kind             (o_kind),
        .o_opcode           (o_opcode),
        .o_data_size        (o_data_size),
        .o_addr_size        (o_addr_size),
        .o_segment_override (o_segment_override),
        .o_rep_mode         (o_rep_mode),
        .o_mod_field        (o_mod_field),
        .o_reg_number       (o_reg_number),
        .o_rm_number        (o_rm_number),
        .o_reg_data         (o_reg_data),
        .o_rm_data          (o_rm_data),
        .o_length           (o_length)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output stage can drain");

    a_non_operand_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_OPERAND) |->
            (o_reg_data == 64'd0 && o_rm_data == 64'd0 && o_mod_field == 2'd0
             && o_reg_number == 4'd0 && o_rm_number == 4'd0))
        else $error("operand fields set on opcode or error result");

    a_error_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_ERROR) |-> (o_opcode == 16'd0))
        else $error("error result carries an opcode");

    a_operand_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_OPERAND) |-> (o_length >= 5'd2))
        else $error("operand result shorter than opcode plus ModRM");

endmodule

>>> bench/tb_x86_prefix_modrm_decoder.sv
// ----------------------------------------------------------------------------
// tb_x86_prefix_modrm_decoder
// Self-checking bench for the byte-serial x86-64 prefix/ModRM decoder.
// ----------------------------------------------------------------------------
// A queue of requests is filled phase by phase: a short directed part, then
// randomized instructions (register loads, prefixes, one- and two-byte
// opcodes, ModRM/SIB/displacement bytes) mixed with truncated sequences and
// out-of-phase noise. A clocked driver offers the requests, a clocked
// monitor takes the results, and an in-bench decoder model predicts each
// result as its request is accepted. Each phase uses its own idle and stall
// pattern; one phase holds the output off long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_x86_prefix_modrm_decoder;
    import xpmd_pkg::*;

    logic        i_clk;
    logic        i_rst_n            = 1'b0;
    logic        i_valid            = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command          = CMD_LOAD;
    logic [4:0]  i_reg_index        = '0;
    logic [63:0] i_reg_value        = '0;
    logic [7:0]  i_byte_value       = '0;
    logic        o_valid;
    logic        i_stall            = 1'b0;
    logic [1:0]  o_kind;
    logic [15:0] o_opcode;
    logic [1:0]  o_data_size;
    logic [1:0]  o_addr_size;
    logic [1:0]  o_segment_override;
    logic [1:0]  o_rep_mode;
    logic [1:0]  o_mod_field;
    logic [3:0]  o_reg_number;
    logic [3:0]  o_rm_number;
    logic [63:0] o_reg_data;
    logic [63:0] o_rm_data;
    logic [4:0]  o_length;

    x86_prefix_modrm_decoder DUT (.*);

    typedef enum {MODE_FREE, MODE_SEND_SLOW, MODE_RECV_SLOW, MODE_BOTH, MODE_PRESSURE} t_mode;

    typedef struct packed {
        t_cmd        cmd;
        logic [4:0]  idx;
        logic [63:0] val;
        logic [7:0]  bval;
    } t_request;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] opcode;
        logic [1:0]  dsize;
        logic [1:0]  asize;
        logic [1:0]  seg;
        logic [1:0]  rep;
        logic [1:0]  mod;
        logic [3:0]  regn;
        logic [3:0]  rmn;
        logic [63:0] regd;
        logic [63:0] rmd;
        logic [4:0]  len;
    } t_decoded;

    t_request pend_q[$];
    t_decoded decoded_q[$];
    t_mode    mode      = MODE_FREE;
    logic     hold_on   = 1'b0;
    int       errors    = 0;
    int       n_queued  = 0;

    // decoder model state
    logic [63:0] rf [0:16];
    logic [7:0]  rex;
    logic [1:0]  opsz, adsz, segsel, repsel;
    t_phase      phase;
    logic [4:0]  npfx, nbytes;
    logic [15:0] opc;
    logic [7:0]  modrm_b, sib_b;
    logic [31:0] disp_acc;
    int          disp_left;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit is_prefix(logic [7:0] b);
        if (b >= REX_FIRST && b <= REX_LAST) return 1'b1;
        case (b)
            PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS, PFX_OPSIZE,
            PFX_ADSIZE, PFX_LOCK, PFX_REPNZ, PFX_REPZ: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int disp_need(logic [7:0] m, logic [7:0] s);
        if (m[7:6] == MOD_DISP8) return 1;
        if (m[7:6] == MOD_DISP32) return 4;
        if (m[7:6] == MOD_MEM0) begin
            if (m[2:0] == RM_DISP) return 4;
            if (m[2:0] == RM_SIB && s[2:0] == RM_DISP) return 4;
        end
        return 0;
    endfunction

    task automatic clear_instr();
        rex       = '0;
        opsz      = SZ32;
        adsz      = SZ64;
        segsel    = SEG_NONE;
        repsel    = REP_NONE;
        npfx      = '0;
        nbytes    = '0;
        opc       = '0;
        modrm_b   = '0;
        sib_b     = '0;
        disp_acc  = '0;
        disp_left = 0;
    endtask

    function automatic t_decoded base_result(t_kind k);
        t_decoded d;
        d        = '0;
        d.kind   = k;
        d.opcode = (k == KIND_ERROR) ? 16'h0 : opc;
        d.dsize  = opsz;
        d.asize  = adsz;
        d.seg    = segsel;
        d.rep    = repsel;
        d.len    = nbytes;
        return d;
    endfunction

    function automatic t_decoded operand_result();
        t_decoded    d;
        logic [1:0]  mod;
        logic [2:0]  rmlo;
        logic [3:0]  regn, rmn, xi;
        logic [63:0] dv, ea;
        int          n;
        mod  = modrm_b[7:6];
        rmlo = modrm_b[2:0];
        regn = {rex[2], modrm_b[5:3]};
        rmn  = {rex[0], rmlo};
        n    = disp_need(modrm_b, sib_b);
        if (n == 1) dv = {{56{disp_acc[7]}}, disp_acc[7:0]};
        else if (n == 4) dv = {{32{disp_acc[31]}}, disp_acc};
        else dv = '0;
        if (mod == MOD_REG) begin
            ea = rf[rmn];
        end else if (mod == MOD_MEM0 && rmlo == RM_DISP) begin
            ea = rf[RIP_ADDR] + dv;
        end else begin
            ea = dv;
            if (rmlo == RM_SIB) begin
                xi = {rex[1], sib_b[5:3]};
                if (xi != IDX_NONE) ea = ea + (rf[xi] << sib_b[7:6]);
                if (!(sib_b[2:0] == RM_DISP && mod == MOD_MEM0))
                    ea = ea + rf[{rex[0], sib_b[2:0]}];
            end else begin
                ea = ea + rf[rmn];
            end
        end
        d      = base_result(KIND_OPERAND);
        d.mod  = mod;
        d.regn = regn;
        d.rmn  = rmn;
        d.regd = rf[regn];
        d.rmd  = ea;
        return d;
    endfunction

    // advance the model by one accepted request, queue any result it yields
    task automatic decode_step(t_cmd cmd, logic [4:0] idx, logic [63:0] val, logic [7:0] b);
        t_decoded d;
        bit       emit, spec_done;
        int       n, got;
        emit      = 1'b0;
        spec_done = 1'b0;
        case (cmd)
            CMD_LOAD: begin
                if (idx <= RIP_ADDR) rf[idx] = val;
            end
            CMD_START: begin
                clear_instr();
                phase = PH_PREFIX;
            end
            CMD_OPBYTE: begin
                if (phase == PH_SECOND) begin
                    nbytes = nbytes + 1'b1;
                    opc    = {OPC_ESCAPE, b};
                    phase  = PH_MODRM;
                    d      = base_result(KIND_OPCODE);
                    emit   = 1'b1;
                end else if (phase == PH_PREFIX) begin
                    nbytes = nbytes + 1'b1;
                    if (!is_prefix(b)) begin
                        opc = {8'h00, b};
                        if (b == OPC_ESCAPE) begin
                            phase = PH_SECOND;
                        end else begin
                            phase = PH_MODRM;
                            d     = base_result(KIND_OPCODE);
                            emit  = 1'b1;
                        end
                    end else begin
                        if (b >= REX_FIRST && b <= REX_LAST) begin
                            rex = b;
                            if (b[3]) opsz = SZ64;
                        end else if (b == PFX_FS) begin
                            segsel = SEG_FS;
                        end else if (b == PFX_GS) begin
                            segsel = SEG_GS;
                        end else if (b == PFX_OPSIZE) begin
                            if (rex == 8'h00) opsz = SZ16;
                        end else if (b == PFX_ADSIZE) begin
                            adsz = SZ32;
                        end else if (b == PFX_REPZ) begin
                            repsel = REP_Z;
                        end else if (b == PFX_REPNZ) begin
                            repsel = REP_NZ;
                        end
                        // legacy segments and lock only count
                        npfx = npfx + 1'b1;
                        if (npfx > PREFIX_LIMIT) begin
                            phase = PH_ERROR;
                            d     = base_result(KIND_ERROR);
                            emit  = 1'b1;
                        end
                    end
                end
            end
            CMD_MODBYTE: begin
                if (phase == PH_MODRM) begin
                    nbytes  = nbytes + 1'b1;
                    modrm_b = b;
                    if (b[7:6] != MOD_REG && b[2:0] == RM_SIB) phase = PH_SIB;
                    else spec_done = 1'b1;
                end else if (phase == PH_SIB) begin
                    nbytes    = nbytes + 1'b1;
                    sib_b     = b;
                    spec_done = 1'b1;
                end else if (phase == PH_DISP) begin
                    nbytes    = nbytes + 1'b1;
                    got       = disp_need(modrm_b, sib_b) - disp_left;
                    disp_acc  = disp_acc | (32'(b) << (8 * got));
                    disp_left = disp_left - 1;
                    if (disp_left == 0) begin
                        d     = operand_result();
                        phase = PH_DONE;
                        emit  = 1'b1;
                    end
                end
            end
        endcase
        if (spec_done) begin
            n = disp_need(modrm_b, sib_b);
            if (n == 0) begin
                d     = operand_result();
                phase = PH_DONE;
                emit  = 1'b1;
            end else begin
                disp_acc  = '0;
                disp_left = n;
                phase     = PH_DISP;
            end
        end
        if (emit) decoded_q.push_back(d);
    endtask

    function automatic bit sender_pauses();
        case (mode)
            MODE_SEND_SLOW: return $urandom_range(0, 99) < 88;
            MODE_BOTH:      return $urandom_range(0, 99) < 17;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_pauses();
        case (mode)
            MODE_RECV_SLOW: return $urandom_range(0, 99) < 88;
            MODE_BOTH:      return $urandom_range(0, 99) < 17;
            default:        return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin : req_drv
        t_request nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                decode_step(t_cmd'(i_command), i_reg_index, i_reg_value, i_byte_value);
            // hold a stalled request, otherwise offer the next one or idle
            if (!i_valid || !o_stall) begin
                if (pend_q.size() != 0 && !sender_pauses()) begin
                    nxt          = pend_q.pop_front();
                    i_valid      <= 1'b1;
                    i_command    <= nxt.cmd;
                    i_reg_index  <= nxt.idx;
                    i_reg_value  <= nxt.val;
                    i_byte_value <= nxt.bval;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_mon
        t_decoded w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("result with nothing pending: kind %0d opcode 0x%0h", o_kind, o_opcode);
                    errors++;
                end else begin
                    w = decoded_q.pop_front();
                    check_field("kind", w.kind, o_kind);
                    check_field("opcode", w.opcode, o_opcode);
                    check_field("data_size", w.dsize, o_data_size);
                    check_field("addr_size", w.asize, o_addr_size);
                    check_field("segment_override", w.seg, o_segment_override);
                    check_field("rep_mode", w.rep, o_rep_mode);
                    check_field("mod_field", w.mod, o_mod_field);
                    check_field("reg_number", w.regn, o_reg_number);
                    check_field("rm_number", w.rmn, o_rm_number);
                    check_field("reg_data", w.regd, o_reg_data);
                    check_field("rm_data", w.rmd, o_rm_data);
                    check_field("length", w.len, o_length);
                end
            end
            i_stall <= hold_on || receiver_pauses();
        end
    end

    // long output hold-off while the sender keeps offering
    initial begin
        while (mode != MODE_PRESSURE) @(posedge i_clk);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin
        #3000000;
        $display("x86_prefix_modrm_decoder regression: fail");
        $finish;
    end

    task automatic put(t_cmd c, logic [7:0] b);
        t_request r;
        r.cmd  = c;
        r.idx  = 5'($urandom);
        r.val  = {$urandom, $urandom};
        r.bval = b;
        pend_q.push_back(r);
        n_queued++;
    endtask

    task automatic put_load(logic [4:0] idx, logic [63:0] v);
        t_request r;
        r.cmd  = CMD_LOAD;
        r.idx  = idx;
        r.val  = v;
        r.bval = 8'($urandom);
        pend_q.push_back(r);
        n_queued++;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 64'h0;
            1:       return '1;
            2:       return 64'($urandom_range(0, 255));
            3:       return {32'hFFFF_FFFF, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [7:0] pick_prefix();
        case ($urandom_range(0, 14))
            0, 1, 2, 3: return REX_FIRST + 8'($urandom_range(0, 15));
            4:          return PFX_ES;
            5:          return PFX_CS;
            6:          return PFX_SS;
            7:          return PFX_DS;
            8:          return PFX_FS;
            9:          return PFX_GS;
            10:         return PFX_OPSIZE;
            11:         return PFX_ADSIZE;
            12:         return PFX_LOCK;
            13:         return PFX_REPNZ;
            default:    return PFX_REPZ;
        endcase
    endfunction

    function automatic logic [7:0] pick_opcode();
        logic [7:0] b;
        do b = 8'($urandom); while (is_prefix(b) || b == OPC_ESCAPE);
        return b;
    endfunction

    task automatic put_instruction();
        int         npre;
        logic [7:0] m, s;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) put_load(5'($urandom_range(0, 16)), rand_word());
        if ($urandom_range(0, 19) == 0) put_load(5'($urandom_range(17, 31)), rand_word());
        put(CMD_START, 8'($urandom));
        npre = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 17) : $urandom_range(0, 4);
        repeat (npre) put(CMD_OPBYTE, pick_prefix());
        if ($urandom_range(0, 19) == 0) put(CMD_MODBYTE, 8'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            put(CMD_OPBYTE, OPC_ESCAPE);
            put(CMD_OPBYTE, 8'($urandom));
        end else begin
            put(CMD_OPBYTE, pick_opcode());
        end
        // drop the operand bytes now and then
        if ($urandom_range(0, 14) == 0) return;
        if ($urandom_range(0, 19) == 0) put(CMD_OPBYTE, 8'($urandom));
        m = 8'($urandom);
        s = 8'($urandom);
        put(CMD_MODBYTE, m);
        if (m[7:6] != MOD_REG && m[2:0] == RM_SIB) put(CMD_MODBYTE, s);
        repeat (disp_need(m, s)) put(CMD_MODBYTE, 8'($urandom));
        if ($urandom_range(0, 9) == 0) put(t_cmd'($urandom_range(2, 3)), 8'($urandom));
    endtask

    task automatic drain();
        while (!(pend_q.size() == 0 && !i_valid && decoded_q.size() == 0)) @(negedge i_clk);
    endtask

    task automatic run_phase(t_mode m, int nitems);
        mode     <= m;
        n_queued = 0;
        while (n_queued < nitems) put_instruction();
        drain();
    endtask

    initial begin
        foreach (rf[k]) rf[k] = '0;
        clear_instr();
        phase = PH_IDLE;

        // bytes before any start are dropped
        put(CMD_MODBYTE, 8'hFF);
        put(CMD_OPBYTE, 8'h00);
        put_load(RIP_ADDR, 64'h0000_0000_0000_1000);
        put_load(5'd13, '1);
        put_load(5'd17, '1);
        // all prefix kinds, operand-size after REX, rip-relative with REX.B set
        put(CMD_START, 8'h00);
        put(CMD_OPBYTE, PFX_OPSIZE);
        put(CMD_OPBYTE, 8'h49);
        put(CMD_OPBYTE, PFX_OPSIZE);
        put(CMD_OPBYTE, PFX_ADSIZE);
        put(CMD_OPBYTE, PFX_GS);
        put(CMD_OPBYTE, PFX_REPZ);
        put(CMD_OPBYTE, PFX_REPNZ);
        put(CMD_OPBYTE, PFX_LOCK);
        put(CMD_OPBYTE, PFX_CS);
        put(CMD_OPBYTE, 8'h8B);
        put(CMD_MODBYTE, 8'h05);
        repeat (4) put(CMD_MODBYTE, 8'hFF);
        // two-byte opcode, register operand, then a stray byte
        put(CMD_START, 8'hFF);
        put(CMD_OPBYTE, OPC_ESCAPE);
        put(CMD_OPBYTE, 8'hFF);
        put(CMD_MODBYTE, 8'hC4);
        put(CMD_OPBYTE, 8'h90);

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        run_phase(MODE_FREE, 230);
        run_phase(MODE_SEND_SLOW, 230);
        run_phase(MODE_RECV_SLOW, 230);
        run_phase(MODE_BOTH, 230);
        run_phase(MODE_PRESSURE, 100);

        repeat (20) @(posedge i_clk);
        if (errors == 0 && decoded_q.size() == 0)
            $display("x86_prefix_modrm_decoder regression: pass");
        else
            $display("x86_prefix_modrm_decoder regression: fail");
        $finish;
    end

endmodule
